@@ design/ilq_pkg.sv @@
package ilq_pkg;

   localparam int IN_MAX  = 256;
   localparam int OUT_MAX = 64;
   localparam int IN_AW   = $clog2(IN_MAX);
   localparam int OUT_AW  = $clog2(OUT_MAX);
   localparam int W_AW    = IN_AW + OUT_AW;
   localparam int W_DEPTH = IN_MAX * OUT_MAX;

   localparam int ACC_W = 24;   // 256 terms of 8x8 products
   localparam int MAG_W = 22;   // |dot product| < 2^22

   localparam logic [1:0] OP_WEIGHT = 2'd0;
   localparam logic [1:0] OP_BIAS   = 2'd1;
   localparam logic [1:0] OP_ACT    = 2'd2;

   localparam logic [1:0] REG_IN_COUNT  = 2'd0;
   localparam logic [1:0] REG_OUT_COUNT = 2'd1;
   localparam logic [1:0] REG_SCALE     = 2'd2;

   localparam logic [8:0]  IN_COUNT_RST  = 9'd128;
   localparam logic [6:0]  OUT_COUNT_RST = 7'd64;
   localparam logic [31:0] SCALE_RST     = 32'h0100_0000;

   localparam logic [8:0] IN_LIMIT  = 9'(IN_MAX);
   localparam logic [6:0] OUT_LIMIT = 7'(OUT_MAX);

   // half of 127*2^24, for rounding half up before dividing
   localparam logic [86:0] RND_HALF = 87'(127) << 23;
   // quotients above 2^40 saturate there
   localparam logic [62:0] SAT_LIM  = 63'd139637976727679;
   localparam logic [40:0] Q_SAT    = 41'h100_0000_0000;
   localparam logic [7:0]  DIV_127  = 8'd127;

endpackage

@@ design/int8_dynamic_quant_linear_unit.sv @@
// int8 matrix-vector multiply with dynamic absmax activation quantization.
// Request channel (req_*): op 0 writes an int8 weight at (row, col), op 1 a
// Q16.16 bias for a row, op 2 an activation at col. An activation beat with
// last set starts a computation over in_count activations and out_count rows,
// capped at 256 and 64. Response channel (rsp_*): one beat per row, in row
// order, out_last on the final row. Weights, activations and quantized values
// live in RAMs with a registered read port; biases in a RAM whose rows read as
// zero until written. A load beat leaves req_ready high. A computation runs
// an absmax scan over the in_count activations, quantizes each element with a
// 7-step divider, then for each row does one MAC per weight read from the
// weight RAM and runs the rescaling unit (three multiplies and a shift-add
// divide by 127). req_ready is low while it runs.
// A stalled response holds the block before the next row is started.
// Reset clears the control state, the bias valid bits and the registers to
// in_count 128, out_count 64, weight_scale 1.0 (Q8.24). No clearing pass.
// Registers: in_count at 0x0, out_count at 0x4, weight_scale at 0x8.
module int8_dynamic_quant_linear_unit
   import ilq_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_op,
   input  logic [5:0]         req_row,
   input  logic [7:0]         req_col,
   input  logic signed [7:0]  req_weight,
   input  logic signed [31:0] req_value,
   input  logic               req_last,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [5:0]         rsp_out_row,
   output logic signed [31:0] rsp_out_value,
   output logic               rsp_out_last,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [3:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_MAX  = 4'd1;
   localparam logic [3:0] S_QRD  = 4'd2;
   localparam logic [3:0] S_QLD  = 4'd3;
   localparam logic [3:0] S_QDIV = 4'd4;
   localparam logic [3:0] S_QWR  = 4'd5;
   localparam logic [3:0] S_MAC  = 4'd6;
   localparam logic [3:0] S_SCL  = 4'd7;
   localparam logic [3:0] S_OUT  = 4'd8;

   logic [8:0]  in_count_ff, in_count_in;
   logic [6:0]  out_count_ff, out_count_in;
   logic [31:0] scale_ff, scale_in;

   logic [3:0]              state_ff, state_in;
   logic [8:0]              cnt_ff, cnt_in;
   logic                    rvld_ff, rvld_in;
   logic [31:0]             m_ff, m_in;
   logic [40:0]             qrem_ff, qrem_in;
   logic [32:0]             qden_ff, qden_in;
   logic [6:0]              qquo_ff, qquo_in;
   logic [2:0]              qstep_ff, qstep_in;
   logic                    qneg_ff, qneg_in;
   logic [OUT_AW-1:0]       row_ff, row_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic [OUT_MAX-1:0]      bvalid_ff, bvalid_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [5:0]              rsp_row_ff, rsp_row_in;
   logic signed [31:0]      rsp_value_ff, rsp_value_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic [8:0]  n_eff;
   logic [6:0]  rows_eff;
   logic        req_fire, csr_wr;
   logic        w_we, b_we, a_we, q_we;
   logic [7:0]  q_wdata;
   logic [W_AW-1:0]  w_raddr;
   logic [IN_AW-1:0] a_raddr;
   logic [7:0]  w_rdata, q_rdata;
   logic [31:0] a_rdata, b_rdata, a_abs;
   logic signed [31:0] bias_eff;
   logic [40:0] qcmp;
   logic        scl_start, scl_done;
   logic signed [31:0] scl_result;
   logic signed [15:0] prod;

   assign n_eff     = (in_count_ff > IN_LIMIT) ? IN_LIMIT : in_count_ff;
   assign rows_eff  = (out_count_ff > OUT_LIMIT) ? OUT_LIMIT : out_count_ff;
   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_wr    = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      case (csr_paddr[3:2])
         REG_IN_COUNT:  csr_prdata = {23'd0, in_count_ff};
         REG_OUT_COUNT: csr_prdata = {25'd0, out_count_ff};
         REG_SCALE:     csr_prdata = scale_ff;
         default:       csr_prdata = 32'd0;
      endcase
   end

   always_comb begin
      in_count_in  = in_count_ff;
      out_count_in = out_count_ff;
      scale_in     = scale_ff;
      if (csr_wr) begin
         case (csr_paddr[3:2])
            REG_IN_COUNT:  in_count_in  = csr_pwdata[8:0];
            REG_OUT_COUNT: out_count_in = csr_pwdata[6:0];
            REG_SCALE:     scale_in     = csr_pwdata;
            default:       ;
         endcase
      end
   end

   assign w_we = req_fire && (req_op == OP_WEIGHT);
   assign b_we = req_fire && (req_op == OP_BIAS);
   assign a_we = req_fire && (req_op == OP_ACT);

   assign a_abs    = a_rdata[31] ? 32'(-a_rdata) : a_rdata;
   assign bias_eff = bvalid_ff[row_ff] ? $signed(b_rdata) : 32'sd0;
   assign qcmp     = 41'(qden_ff) << qstep_ff;
   assign prod     = $signed(w_rdata) * $signed(q_rdata);
   assign w_raddr  = {row_ff, cnt_ff[IN_AW-1:0]};
   assign a_raddr  = cnt_ff[IN_AW-1:0];
   assign q_we     = (state_ff == S_QWR);
   assign q_wdata  = (m_ff == 32'd0) ? 8'd0 :
                     (qneg_ff ? 8'(-{1'b0, qquo_ff}) : {1'b0, qquo_ff});

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rvld_in      = 1'b0;
      m_in         = m_ff;
      qrem_in      = qrem_ff;
      qden_in      = qden_ff;
      qquo_in      = qquo_ff;
      qstep_in     = qstep_ff;
      qneg_in      = qneg_ff;
      row_in       = row_ff;
      acc_in       = acc_ff;
      bvalid_in    = bvalid_ff;
      scl_start    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_row_in   = rsp_row_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      if (b_we) begin
         bvalid_in[req_row] = 1'b1;
      end
      case (state_ff)
         S_IDLE: begin
            if (a_we && req_last) begin
               cnt_in   = 9'd0;
               m_in     = 32'd0;
               state_in = S_MAX;
            end
         end
         S_MAX: begin
            if (rvld_ff && (a_abs > m_ff)) begin
               m_in = a_abs;
            end
            if (cnt_ff != n_eff) begin
               rvld_in = 1'b1;
               cnt_in  = cnt_ff + 9'd1;
            end else if (!rvld_ff) begin
               cnt_in   = 9'd0;
               state_in = S_QRD;
            end
         end
         S_QRD: begin
            if (cnt_ff == n_eff) begin
               cnt_in = 9'd0;
               row_in = '0;
               acc_in = '0;
               state_in = (rows_eff == 7'd0) ? S_IDLE : S_MAC;
            end else begin
               state_in = S_QLD;
            end
         end
         S_QLD: begin
            // round half away: floor((254*|x| + m) / (2*m))
            qrem_in  = 41'({a_abs, 8'd0}) - 41'({a_abs, 1'b0}) + 41'(m_ff);
            qden_in  = {m_ff, 1'b0};
            qneg_in  = a_rdata[31];
            qquo_in  = 7'd0;
            qstep_in = 3'd6;
            state_in = S_QDIV;
         end
         S_QDIV: begin
            if (qrem_ff >= qcmp) begin
               qrem_in = qrem_ff - qcmp;
               qquo_in = {qquo_ff[5:0], 1'b1};
            end else begin
               qquo_in = {qquo_ff[5:0], 1'b0};
            end
            qstep_in = qstep_ff - 3'd1;
            if (qstep_ff == 3'd0) begin
               state_in = S_QWR;
            end
         end
         S_QWR: begin
            cnt_in   = cnt_ff + 9'd1;
            state_in = S_QRD;
         end
         S_MAC: begin
            if (rvld_ff) begin
               acc_in = acc_ff + ACC_W'(prod);
            end
            if (cnt_ff != n_eff) begin
               rvld_in = 1'b1;
               cnt_in  = cnt_ff + 9'd1;
            end else if (!rvld_ff) begin
               scl_start = 1'b1;
               state_in  = S_SCL;
            end
         end
         S_SCL: begin
            if (scl_done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_row_in   = 6'(row_ff);
               rsp_value_in = scl_result;
               rsp_last_in  = (7'(row_ff) + 7'd1 == rows_eff);
               cnt_in       = 9'd0;
               acc_in       = '0;
               row_in       = row_ff + OUT_AW'(1);
               state_in     = rsp_last_in ? S_IDLE : S_MAC;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_count_ff  <= IN_COUNT_RST;
         out_count_ff <= OUT_COUNT_RST;
         scale_ff     <= SCALE_RST;
         state_ff     <= S_IDLE;
         rvld_ff      <= 1'b0;
         bvalid_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_count_ff  <= in_count_in;
         out_count_ff <= out_count_in;
         scale_ff     <= scale_in;
         state_ff     <= state_in;
         rvld_ff      <= rvld_in;
         bvalid_ff    <= bvalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cnt_ff       <= cnt_in;
      m_ff         <= m_in;
      qrem_ff      <= qrem_in;
      qden_ff      <= qden_in;
      qquo_ff      <= qquo_in;
      qstep_ff     <= qstep_in;
      qneg_ff      <= qneg_in;
      row_ff       <= row_in;
      acc_ff       <= acc_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   ilq_ram #(.WIDTH(8), .DEPTH(W_DEPTH)) u_weight (
      .clock (clock),
      .we    (w_we),
      .waddr ({req_row, req_col}),
      .wdata (req_weight),
      .raddr (w_raddr),
      .rdata (w_rdata)
   );

   // read the upcoming row so its bias is ready on the first row cycle
   ilq_ram #(.WIDTH(32), .DEPTH(OUT_MAX)) u_bias (
      .clock (clock),
      .we    (b_we),
      .waddr (req_row),
      .wdata (req_value),
      .raddr (row_in),
      .rdata (b_rdata)
   );

   ilq_ram #(.WIDTH(32), .DEPTH(IN_MAX)) u_act (
      .clock (clock),
      .we    (a_we),
      .waddr (req_col),
      .wdata (req_value),
      .raddr (a_raddr),
      .rdata (a_rdata)
   );

   ilq_ram #(.WIDTH(8), .DEPTH(IN_MAX)) u_quant (
      .clock (clock),
      .we    (q_we),
      .waddr (cnt_ff[IN_AW-1:0]),
      .wdata (q_wdata),
      .raddr (a_raddr),
      .rdata (q_rdata)
   );

   ilq_scale u_scale (
      .clock  (clock),
      .reset  (reset),
      .start  (scl_start),
      .acc    (acc_ff),
      .absmax (m_ff),
      .scale  (scale_ff),
      .bias   (bias_eff),
      .done   (scl_done),
      .result (scl_result)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_row   = rsp_row_ff;
   assign rsp_out_value = rsp_value_ff;
   assign rsp_out_last  = rsp_last_ff;

endmodule

@@ design/ilq_ram.sv @@
module ilq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ design/ilq_scale.sv @@
module ilq_scale
   import ilq_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [ACC_W-1:0] acc,
   input  logic [31:0]             absmax,
   input  logic [31:0]             scale,
   input  logic signed [31:0]      bias,
   output logic                    done,
   output logic signed [31:0]      result
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_MT   = 4'd1;
   localparam logic [3:0] S_MP0  = 4'd2;
   localparam logic [3:0] S_MP1  = 4'd3;
   localparam logic [3:0] S_SUM  = 4'd4;
   localparam logic [3:0] S_R1   = 4'd5;
   localparam logic [3:0] S_R2   = 4'd6;
   localparam logic [3:0] S_R3   = 4'd7;
   localparam logic [3:0] S_FIX  = 4'd8;
   localparam logic [3:0] S_FIN  = 4'd9;

   logic [3:0]         state_ff, state_in;
   logic [MAG_W-1:0]   mag_ff, mag_in;
   logic               neg_ff, neg_in;
   logic [31:0]        m_ff, m_in, sc_ff, sc_in;
   logic signed [31:0] bias_ff, bias_in;
   logic [53:0]        t_ff, t_in;
   logic [63:0]        p0_ff, p0_in;
   logic [53:0]        p1_ff, p1_in;
   logic               sat_ff, sat_in;
   logic [46:0]        y_ff, y_in;
   logic [96:0]        p_ff, p_in;
   logic [40:0]        q_ff, q_in;
   logic signed [31:0] res_ff, res_in;
   logic               done_ff, done_in;

   logic [ACC_W-1:0]   acc_abs;
   logic [86:0]        psum;
   logic [62:0]        yq;
   logic [40:0]        q_est;
   logic [47:0]        r127;
   logic [40:0]        qv;
   logic signed [41:0] sum;

   always_comb begin
      acc_abs  = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
      psum     = {p1_ff, 32'd0} + {23'd0, p0_ff} + RND_HALF;
      yq       = psum[86:24];
      // p = y * (2^56-1)/127, so p >> 56 is y/127 or one less
      q_est    = p_ff[96:56];
      r127     = 48'(y_ff) - {q_est, 7'd0} + 48'(q_est);
      qv       = sat_ff ? Q_SAT : q_ff;
      sum      = 42'(bias_ff) + (neg_ff ? -$signed({1'b0, qv}) : $signed({1'b0, qv}));
      state_in = state_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      m_in     = m_ff;
      sc_in    = sc_ff;
      bias_in  = bias_ff;
      t_in     = t_ff;
      p0_in    = p0_ff;
      p1_in    = p1_ff;
      sat_in   = sat_ff;
      y_in     = y_ff;
      p_in     = p_ff;
      q_in     = q_ff;
      res_in   = res_ff;
      done_in  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               mag_in   = acc_abs[MAG_W-1:0];
               neg_in   = acc[ACC_W-1];
               m_in     = absmax;
               sc_in    = scale;
               bias_in  = bias;
               state_in = S_MT;
            end
         end
         S_MT: begin
            t_in     = 54'(mag_ff) * 54'(m_ff);
            state_in = S_MP0;
         end
         S_MP0: begin
            p0_in    = 64'(t_ff[31:0]) * 64'(sc_ff);
            state_in = S_MP1;
         end
         S_MP1: begin
            p1_in    = 54'(t_ff[53:32]) * 54'(sc_ff);
            state_in = S_SUM;
         end
         S_SUM: begin
            sat_in   = yq >= SAT_LIM;
            y_in     = yq[46:0];
            state_in = S_R1;
         end
         S_R1: begin
            p_in     = 97'(y_ff) + (97'(y_ff) << 7);
            state_in = S_R2;
         end
         S_R2: begin
            p_in     = p_ff + (p_ff << 14);
            state_in = S_R3;
         end
         S_R3: begin
            p_in     = p_ff + (p_ff << 28);
            state_in = S_FIX;
         end
         S_FIX: begin
            q_in     = (r127 >= 48'(DIV_127)) ? q_est + 41'd1 : q_est;
            state_in = S_FIN;
         end
         S_FIN: begin
            if (sum[41:31] == {11{sum[41]}}) begin
               res_in = sum[31:0];
            end else begin
               res_in = sum[41] ? 32'sh8000_0000 : 32'sh7fff_ffff;
            end
            done_in  = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      m_ff    <= m_in;
      sc_ff   <= sc_in;
      bias_ff <= bias_in;
      t_ff    <= t_in;
      p0_ff   <= p0_in;
      p1_ff   <= p1_in;
      sat_ff  <= sat_in;
      y_ff    <= y_in;
      p_ff    <= p_in;
      q_ff    <= q_in;
      res_ff  <= res_in;
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

@@ design/ilq_checker.sv @@
module ilq_checker
   import ilq_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic [1:0]         req_op,
   input logic               req_last,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [31:0] rsp_out_value,
   input logic               csr_pready
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_value))
      else $error("stalled response beat changed");

   a_pready: assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("pready low");

   // the last activation starts a computation that blocks the input
   a_start: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_op == OP_ACT && req_last |=> !req_ready)
      else $error("input not blocked after last activation");

   // weight and bias load beats never leave the block busy
   a_load: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_op != OP_ACT |=> req_ready)
      else $error("input blocked after a load beat");

endmodule

bind int8_dynamic_quant_linear_unit ilq_checker u_ilq_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_op        (req_op),
   .req_last      (req_last),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_out_value (rsp_out_value),
   .csr_pready    (csr_pready)
);
